/* hdl/lpi_pkg.sv */
// Package for the line pixel interpolator: coordinate width, line descriptor,
// queue sizing and back-end state encoding. No dependencies.
`default_nettype none

package lpi_pkg;

    localparam int COORD_BITS = 6;
    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_BITS = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int QCNT_BITS = $clog2(QUEUE_DEPTH + 1);

    typedef logic [COORD_BITS-1:0] coord_t;

    // Line normalized to its major axis, walking upward along it
    typedef struct packed {
        logic   x_major;
        logic   db_neg;
        coord_t a0;
        coord_t b0;
        coord_t da;
        coord_t adb;
    } line_desc_t;

    typedef enum logic {
        BACK_IDLE,
        BACK_RUN
    } back_state_t;

    typedef struct packed {
        logic busy;
        logic emit;
        logic emit_last;
    } back_status_t;

endpackage

`default_nettype wire

/* hdl/lpi_ifs.sv */
// Valid/ready channel interfaces for line requests and emitted pixels.
// Depends on lpi_pkg.
`default_nettype none

interface line_req_if;
    import lpi_pkg::*;

    logic   valid;
    logic   ready;
    coord_t start_x;
    coord_t start_y;
    coord_t stop_x;
    coord_t stop_y;

    modport source (output valid, output start_x, output start_y,
                    output stop_x, output stop_y, input ready);
    modport sink   (input valid, input start_x, input start_y,
                    input stop_x, input stop_y, output ready);
endinterface

interface pixel_if;
    import lpi_pkg::*;

    logic   valid;
    logic   ready;
    coord_t pixel_x;
    coord_t pixel_y;
    logic   last_pixel;

    modport source (output valid, output pixel_x, output pixel_y,
                    output last_pixel, input ready);
    modport sink   (input valid, input pixel_x, input pixel_y,
                    input last_pixel, output ready);
endinterface

`default_nettype wire

/* hdl/lpi_front.sv */
// Front end: takes line requests, picks the major axis, orders the endpoints
// and registers one line descriptor. Depends on lpi_pkg and lpi_ifs.
`default_nettype none

module lpi_front (
    input  wire logic              clk,
    input  wire logic              rst_n,
    line_req_if.sink               req,
    output lpi_pkg::line_desc_t    desc,
    output logic                   desc_valid,
    input  wire logic              desc_ready
);
    import lpi_pkg::*;

    logic       front_valid_reg;
    logic       front_valid_next;
    line_desc_t desc_reg;
    line_desc_t desc_next;

    logic [COORD_BITS:0] dx;
    logic [COORD_BITS:0] dy;
    logic [COORD_BITS:0] db;
    coord_t              adx;
    coord_t              ady;
    coord_t              a0;
    coord_t              a1;
    coord_t              b0;
    coord_t              b1;
    logic                x_major;
    logic                swap;

    always_comb
    begin
        dx = {1'b0, req.stop_x} - {1'b0, req.start_x};
        dy = {1'b0, req.stop_y} - {1'b0, req.start_y};
        adx = dx[COORD_BITS] ? COORD_BITS'(-dx) : COORD_BITS'(dx);
        ady = dy[COORD_BITS] ? COORD_BITS'(-dy) : COORD_BITS'(dy);
        // Ties go to x
        x_major = (adx >= ady);
        a0 = x_major ? req.start_x : req.start_y;
        b0 = x_major ? req.start_y : req.start_x;
        a1 = x_major ? req.stop_x  : req.stop_y;
        b1 = x_major ? req.stop_y  : req.stop_x;
        // Walk upward along the major axis
        swap = (a1 < a0);
        desc_next.x_major = x_major;
        desc_next.a0 = swap ? a1 : a0;
        desc_next.b0 = swap ? b1 : b0;
        desc_next.da = swap ? (a0 - a1) : (a1 - a0);
        db = swap ? ({1'b0, b0} - {1'b0, b1}) : ({1'b0, b1} - {1'b0, b0});
        desc_next.db_neg = db[COORD_BITS];
        desc_next.adb = db[COORD_BITS] ? COORD_BITS'(-db) : COORD_BITS'(db);
    end

    assign req.ready = !front_valid_reg || desc_ready;

    always_comb
    begin
        front_valid_next = front_valid_reg;
        if (req.valid && req.ready)
        begin
            front_valid_next = 1'b1;
        end
        else if (desc_ready)
        begin
            front_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            front_valid_reg <= 1'b0;
        end
        else
        begin
            front_valid_reg <= front_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (req.valid && req.ready)
        begin
            desc_reg <= desc_next;
        end
    end

    assign desc       = desc_reg;
    assign desc_valid = front_valid_reg;

endmodule

`default_nettype wire

/* hdl/lpi_queue.sv */
// Short descriptor queue between front and back ends.
// Depends on lpi_pkg.
`default_nettype none

module lpi_queue (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire lpi_pkg::line_desc_t  in_desc,
    input  wire logic                 in_valid,
    output logic                      in_ready,
    output lpi_pkg::line_desc_t       out_desc,
    output logic                      out_valid,
    input  wire logic                 out_ready
);
    import lpi_pkg::*;

    line_desc_t           mem_reg [QUEUE_DEPTH];
    logic [QPTR_BITS-1:0] wr_ptr_reg;
    logic [QPTR_BITS-1:0] wr_ptr_next;
    logic [QPTR_BITS-1:0] rd_ptr_reg;
    logic [QPTR_BITS-1:0] rd_ptr_next;
    logic [QCNT_BITS-1:0] count_reg;
    logic [QCNT_BITS-1:0] count_next;
    logic                 push;
    logic                 pop;

    assign in_ready  = (count_reg != QCNT_BITS'(QUEUE_DEPTH));
    assign out_valid = (count_reg != '0);
    assign out_desc  = mem_reg[rd_ptr_reg];
    assign push      = in_valid && in_ready;
    assign pop       = out_valid && out_ready;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == QPTR_BITS'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == QPTR_BITS'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wr_ptr_reg] <= in_desc;
        end
    end

endmodule

`default_nettype wire

/* hdl/lpi_back.sv */
// Back end: walks one line descriptor a pixel per cycle while the pixel output
// is not stalled, and drives the registered pixel output. Depends on lpi_pkg and lpi_ifs.
`default_nettype none

module lpi_back (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire lpi_pkg::line_desc_t  desc,
    input  wire logic                 desc_valid,
    output logic                      desc_ready,
    pixel_if.source                   pix,
    output lpi_pkg::back_status_t     status
);
    import lpi_pkg::*;

    back_state_t state_reg;
    back_state_t state_next;
    line_desc_t  line_reg;
    coord_t      k_reg;
    coord_t      k_next;
    coord_t      q_reg;
    coord_t      q_next;
    coord_t      r_reg;
    coord_t      r_next;
    logic        out_valid_reg;
    logic        out_valid_next;
    coord_t      out_x_reg;
    coord_t      out_y_reg;
    logic        out_last_reg;

    logic                busy;
    logic                emit;
    logic                last;
    logic                load;
    coord_t              a_cur;
    coord_t              b_cur;
    logic [COORD_BITS:0] r_sum;

    assign busy  = (state_reg == BACK_RUN);
    assign emit  = busy && (!out_valid_reg || pix.ready);
    assign last  = (k_reg == line_reg.da);
    assign a_cur = line_reg.a0 + k_reg;
    assign b_cur = line_reg.db_neg ? (line_reg.b0 - q_reg) : (line_reg.b0 + q_reg);
    // Running quotient and remainder of adb*k/da, one compare-subtract a step
    assign r_sum = {1'b0, r_reg} + {1'b0, line_reg.adb};

    always_comb
    begin
        state_next = state_reg;
        desc_ready = 1'b0;
        load       = 1'b0;
        k_next     = k_reg;
        q_next     = q_reg;
        r_next     = r_reg;
        case (state_reg)
            BACK_IDLE:
            begin
                desc_ready = 1'b1;
                if (desc_valid)
                begin
                    load       = 1'b1;
                    k_next     = '0;
                    q_next     = '0;
                    r_next     = '0;
                    state_next = BACK_RUN;
                end
            end
            BACK_RUN:
            begin
                if (emit)
                begin
                    k_next = k_reg + 1'b1;
                    if (r_sum >= {1'b0, line_reg.da})
                    begin
                        r_next = COORD_BITS'(r_sum - {1'b0, line_reg.da});
                        q_next = q_reg + 1'b1;
                    end
                    else
                    begin
                        r_next = COORD_BITS'(r_sum);
                    end
                    if (last)
                    begin
                        state_next = BACK_IDLE;
                    end
                end
            end
            default:
            begin
                state_next = BACK_IDLE;
            end
        endcase
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (emit)
        begin
            out_valid_next = 1'b1;
        end
        else if (pix.ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= BACK_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            line_reg <= desc;
        end
        k_reg <= k_next;
        q_reg <= q_next;
        r_reg <= r_next;
        if (emit)
        begin
            out_x_reg    <= line_reg.x_major ? a_cur : b_cur;
            out_y_reg    <= line_reg.x_major ? b_cur : a_cur;
            out_last_reg <= last;
        end
    end

    assign pix.valid      = out_valid_reg;
    assign pix.pixel_x    = out_x_reg;
    assign pix.pixel_y    = out_y_reg;
    assign pix.last_pixel = out_last_reg;

    // Fields in declaration order: busy, emit, emit_last
    assign status = {busy, emit, emit && last};

endmodule

`default_nettype wire

/* hdl/line_pixel_interpolator_top.sv */
// Line pixel interpolator top level: rasterizes a line inside a square tile.
// Path: request -> front-end register -> queue -> back-end state -> pixel output register.
// Flow: a line of da+1 pixels (da = major-axis delta) occupies the back end until
//   its last pixel is emitted; a new request is taken while one runs.
// Reset: rst_n clears the queue and all valid flags; no line is in flight.
// Depends on lpi_pkg, lpi_ifs, lpi_front, lpi_queue and lpi_back.
`default_nettype none

module line_pixel_interpolator_top (
    input  wire logic clk,
    input  wire logic rst_n,
    line_req_if.sink  req,
    pixel_if.source   pix
);
    import lpi_pkg::*;

    // Front end output: one classified line descriptor
    line_desc_t   front_desc;
    logic         front_valid;
    logic         front_ready;

    // Queue output toward the pixel walker
    line_desc_t   queue_desc;
    logic         queue_valid;
    logic         queue_ready;

    back_status_t back_status;

    // Classify each request: major axis, endpoint order, deltas
    lpi_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .req        (req),
        .desc       (front_desc),
        .desc_valid (front_valid),
        .desc_ready (front_ready)
    );

    // Hold up to two lines so request intake and pixel output stall independently
    lpi_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_desc   (front_desc),
        .in_valid  (front_valid),
        .in_ready  (front_ready),
        .out_desc  (queue_desc),
        .out_valid (queue_valid),
        .out_ready (queue_ready)
    );

    // Walk the major axis one pixel per transfer; minor coordinate comes from
    // an incremental quotient/remainder, so no divider is needed
    lpi_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .desc       (queue_desc),
        .desc_valid (queue_valid),
        .desc_ready (queue_ready),
        .pix        (pix),
        .status     (back_status)
    );

    // A descriptor pulled from the queue starts a line on the next cycle
    assert property (@(posedge clk) disable iff (!rst_n)
        queue_valid && queue_ready |=> back_status.busy)
        else $error("line load did not start the walker");

    // Emitting the final pixel ends the line
    assert property (@(posedge clk) disable iff (!rst_n)
        back_status.emit_last |=> !back_status.busy)
        else $error("walker still busy after final pixel");

    // The walker takes no new line while one is in progress
    assert property (@(posedge clk) disable iff (!rst_n)
        back_status.busy |-> !queue_ready)
        else $error("queue popped during a line");

    // A pixel is produced only into a free or draining output register
    assert property (@(posedge clk) disable iff (!rst_n)
        back_status.emit |=> pix.valid)
        else $error("emitted pixel not presented");

endmodule

`default_nettype wire
